// ----- src/srde_pkg.sv -----
// srde_pkg: constants, widths and helpers for the signed radix digit emitter
// used by signed_radix_digit_emitter_core and srde_checker; no dependencies
`default_nettype none

package srde_pkg;

   localparam int MAX_SYMBOLS = 16;
   localparam int VALUE_WIDTH = 32;

   // divider retires this many dividend bits per cycle
   localparam int STEP_BITS = 8;
   localparam int DIV_CYCLES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_WIDTH = DIV_CYCLES * STEP_BITS;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_CYCLES + 1);

   // radix 2 needs VALUE_WIDTH digits for the most negative value
   localparam int DIGIT_DEPTH = VALUE_WIDTH;
   localparam int DIGIT_IDX_WIDTH = $clog2(DIGIT_DEPTH);
   localparam int DIGIT_CNT_WIDTH = $clog2(DIGIT_DEPTH + 1);

   localparam int SYM_IDX_WIDTH = 4;
   localparam int RADIX_WIDTH = 5;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHABET_LOW = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHABET_HIGH = 2'd2;

   localparam logic [RADIX_WIDTH-1:0] BASE_LENGTH_RESET = 5'd10;
   localparam logic [63:0] ALPHABET_LOW_RESET = 64'h3736_3534_3332_3130;
   localparam logic [63:0] ALPHABET_HIGH_RESET = 64'h0000_0000_0000_3938;

   localparam logic [7:0] CHAR_PLUS = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;

   function automatic logic [7:0] symbol_at(input logic [127:0] alphabet,
                                            input logic [SYM_IDX_WIDTH-1:0] idx);
      symbol_at = alphabet[{idx, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

// ----- src/signed_radix_digit_emitter_core.sv -----
// signed radix digit emitter: signed integer to text in a configurable base
// alphabet check over the radix symbols, then the 8-bit-per-cycle divider per digit,
// then one character per cycle unless stalled; a radix below 2 or a bad alphabet
// drops the value with no output. one transaction at a time; next value accepted once
// the last character is in the output register. synchronous active-high reset
// restores the decimal alphabet. depends on srde_pkg
`default_nettype none

module signed_radix_digit_emitter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic signed [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_symbol,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [srde_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [63:0] csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam int W = srde_pkg::VALUE_WIDTH;
   localparam int RW = srde_pkg::RADIX_WIDTH;
   localparam int SW = srde_pkg::SYM_IDX_WIDTH;
   localparam int DW = srde_pkg::DIV_WIDTH;
   localparam int NB = srde_pkg::STEP_BITS;
   localparam int CW = srde_pkg::DIV_CNT_WIDTH;
   localparam int IW = srde_pkg::DIGIT_IDX_WIDTH;
   localparam int NW = srde_pkg::DIGIT_CNT_WIDTH;
   localparam logic [RW-1:0] MAX_RADIX = RW'(srde_pkg::MAX_SYMBOLS);

   logic [1:0]      state_ff, state_in;
   logic [RW-1:0]   base_length_ff, base_length_in;
   logic [63:0]     alpha_low_ff, alpha_low_in;
   logic [63:0]     alpha_high_ff, alpha_high_in;
   logic            neg_ff, neg_in;
   logic [DW-1:0]   div_ff, div_in;
   logic [SW-1:0]   rem_ff, rem_in;
   logic [CW-1:0]   div_cnt_ff, div_cnt_in;
   logic [SW-1:0]   chk_idx_ff, chk_idx_in;
   logic [NW-1:0]   nd_ff, nd_in;
   logic            sign_pend_ff, sign_pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_symbol_ff, rsp_symbol_in;
   logic            rsp_last_ff, rsp_last_in;
   logic [SW-1:0]   digit_mem [srde_pkg::DIGIT_DEPTH];
   logic [SW-1:0]   digit_rd_ff;

   logic [127:0]    alphabet;
   logic [RW-1:0]   radix;
   logic [W-1:0]    value_low;
   logic [W-1:0]    magnitude;
   logic            sym_bad;
   logic [7:0]      sym_i;
   logic [SW:0]     trial;
   logic [SW-1:0]   rem_step;
   logic [NB-1:0]   quot_bits;
   logic [DW-1:0]   div_next;
   logic            div_last;
   logic            digit_wr;
   logic [IW-1:0]   rd_idx;
   logic            out_free;

   assign alphabet = {alpha_high_ff, alpha_low_ff};
   assign radix = (base_length_ff > MAX_RADIX) ? MAX_RADIX : base_length_ff;
   assign value_low = req_value[W-1:0];
   assign magnitude = value_low[W-1] ? (~value_low + W'(1)) : value_low;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_idx = IW'(nd_in - NW'(1));
   assign div_last = (div_cnt_ff == CW'(srde_pkg::DIV_CYCLES - 1));

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last = rsp_last_ff;

   // alphabet check for symbol chk_idx against signs and all later used symbols
   always_comb begin
      sym_i = srde_pkg::symbol_at(alphabet, chk_idx_ff);
      sym_bad = (sym_i == srde_pkg::CHAR_PLUS) || (sym_i == srde_pkg::CHAR_MINUS);
      for (int j = 0; j < srde_pkg::MAX_SYMBOLS; j++) begin
         if ((SW'(j) > chk_idx_ff) && (RW'(j) < radix) &&
             (srde_pkg::symbol_at(alphabet, SW'(j)) == sym_i)) begin
            sym_bad = 1'b1;
         end
      end
   end

   // restoring divider slice, NB quotient bits per cycle
   always_comb begin
      rem_step = rem_ff;
      quot_bits = '0;
      trial = '0;
      for (int k = 0; k < NB; k++) begin
         trial = {rem_step, div_ff[DW-1-k]};
         if (trial >= radix) begin
            trial = trial - radix;
            quot_bits[NB-1-k] = 1'b1;
         end
         rem_step = trial[SW-1:0];
      end
      div_next = (div_ff << NB) | DW'(quot_bits);
   end

   always_comb begin
      state_in = state_ff;
      base_length_in = base_length_ff;
      alpha_low_in = alpha_low_ff;
      alpha_high_in = alpha_high_ff;
      neg_in = neg_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      div_cnt_in = div_cnt_ff;
      chk_idx_in = chk_idx_ff;
      nd_in = nd_ff;
      sign_pend_in = sign_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in = rsp_last_ff;
      digit_wr = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            srde_pkg::CSR_BASE_LENGTH: base_length_in = csr_data[RW-1:0];
            srde_pkg::CSR_ALPHABET_LOW: alpha_low_in = csr_data;
            srde_pkg::CSR_ALPHABET_HIGH: alpha_high_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in = value_low[W-1];
               div_in = DW'(magnitude);
               rem_in = '0;
               div_cnt_in = '0;
               chk_idx_in = '0;
               nd_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (radix < RW'(2) || sym_bad) begin
               state_in = ST_IDLE;
            end else if (RW'(chk_idx_ff) == radix - RW'(1)) begin
               state_in = ST_DIVIDE;
            end else begin
               chk_idx_in = chk_idx_ff + SW'(1);
            end
         end
         ST_DIVIDE: begin
            div_in = div_next;
            rem_in = rem_step;
            div_cnt_in = div_cnt_ff + CW'(1);
            if (div_last) begin
               digit_wr = 1'b1;
               nd_in = nd_ff + NW'(1);
               rem_in = '0;
               div_cnt_in = '0;
               if (div_next == '0) begin
                  sign_pend_in = neg_ff;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_pend_ff) begin
                  rsp_symbol_in = srde_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  sign_pend_in = 1'b0;
               end else begin
                  rsp_symbol_in = srde_pkg::symbol_at(alphabet, digit_rd_ff);
                  rsp_last_in = (nd_ff == NW'(1));
                  nd_in = nd_ff - NW'(1);
                  if (nd_ff == NW'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_length_ff <= srde_pkg::BASE_LENGTH_RESET;
         alpha_low_ff <= srde_pkg::ALPHABET_LOW_RESET;
         alpha_high_ff <= srde_pkg::ALPHABET_HIGH_RESET;
         rsp_valid_ff <= 1'b0;
         sign_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_length_ff <= base_length_in;
         alpha_low_ff <= alpha_low_in;
         alpha_high_ff <= alpha_high_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_pend_ff <= sign_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      div_cnt_ff <= div_cnt_in;
      chk_idx_ff <= chk_idx_in;
      nd_ff <= nd_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff <= rsp_last_in;
   end

   // digit buffer, least significant digit at index 0
   // read data is the digit due next; the newest digit is passed straight through
   always_ff @(posedge clock) begin
      if (digit_wr) begin
         digit_mem[IW'(nd_ff)] <= rem_step;
         digit_rd_ff <= rem_step;
      end else begin
         digit_rd_ff <= digit_mem[rd_idx];
      end
   end

endmodule

`default_nettype wire

// ----- src/srde_checker.sv -----
// srde_checker: port-level assertions for signed_radix_digit_emitter_core
// bound to the top level below; depends on srde_pkg
`default_nettype none

module srde_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_symbol,
   input wire logic        rsp_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol) && $stable(rsp_last))
      else $error("stalled result changed");

   // an accepted transaction makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

   // a minus sign always leads digits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_symbol == srde_pkg::CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign marked last");

   // a new transaction starts only after the previous text is complete
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !rsp_valid || rsp_last)
      else $error("input taken mid text");

endmodule

bind signed_radix_digit_emitter_core srde_checker u_srde_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_symbol (rsp_symbol),
   .rsp_last   (rsp_last)
);

`default_nettype wire
